@@ design/srsw_pkg.sv @@
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants of the selective-repeat send window
// Word formats, slot marks, action and result codes, and the cell interface.
// ----------------------------------------------------------------------------
package srsw_pkg;

    localparam int SEQ_W = 16;

    localparam logic [SEQ_W-1:0] MARK_OPEN   = 16'd65535;
    localparam logic [SEQ_W-1:0] MARK_ACKED  = 16'd65534;
    localparam logic [SEQ_W-1:0] FINAL_RESET = 16'd65533;
    localparam logic [7:0]       RESEND_RESET = 8'd10;

    localparam logic [1:0] ACT_SEND    = 2'd0;
    localparam logic [1:0] ACT_ACK     = 2'd1;
    localparam logic [1:0] ACT_TIMEOUT = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    localparam logic [2:0] KIND_TAKEN   = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_ACKED   = 3'd2;
    localparam logic [2:0] KIND_RESEND  = 3'd3;
    localparam logic [2:0] KIND_GIVE_UP = 3'd4;
    localparam logic [2:0] KIND_NONE    = 3'd5;

    localparam logic REG_RETRY_LIMIT = 1'b0;

    typedef struct packed {
        logic [1:0]       action;
        logic [SEQ_W-1:0] seq;
        logic             final_req;
    } in_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [SEQ_W-1:0] seq_res;
        logic             last;
        logic             done_res;
    } out_t;

    typedef struct packed {
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        logic open;
        logic acked;
        logic hit;
    } cell_stat_t;

endpackage

@@ design/selective_repeat_send_window.sv @@
// ----------------------------------------------------------------------------
// selective_repeat_send_window: sender-side window of a selective-repeat link
// A row of slot cells rotates past its head once per send, ack or timeout, where
// sends take an open slot, acks mark slots, and timeouts list pending slots.
//
//   channel   handshake              payload
//   command   start / busy           cmd    (in_t)
//   result    result_valid strobe    result (out_t)
//   config    APB psel / penable     pwdata, prdata
//
// A send or timeout rotates every slot past the head cell once and then closes;
// an ack does the same, then slides out every leading acknowledged slot. A
// timeout at the retry limit gives up without rotating.
// Each word is registered and appears in the cycle after it is formed; the receiver cannot stall.
// Reset opens every slot at once.
// ----------------------------------------------------------------------------
module selective_repeat_send_window
    import srsw_pkg::*;
#(
    parameter int WINDOW_SLOTS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         cmd,
    output logic        result_valid,
    output out_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CNT_W = $clog2(WINDOW_SLOTS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROT   = 2'd1;
    localparam logic [1:0] ST_SLIDE = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             fin_reg, fin_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             placed_reg, placed_next;
    logic             giveup_reg, giveup_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [SEQ_W-1:0] hold_seq_reg, hold_seq_next;
    logic [7:0]       retry_reg, retry_next;
    logic [SEQ_W-1:0] acked_count_reg, acked_count_next;
    logic [SEQ_W-1:0] final_seq_reg, final_seq_next;
    logic [7:0]       retry_limit_reg, retry_limit_next;
    logic             res_valid_reg, res_valid_next;
    out_t             res_reg, res_next;

    cell_ctl_t        cell_ctl;
    logic [SEQ_W-1:0] tail;
    logic [SEQ_W-1:0] slot_w [WINDOW_SLOTS];
    cell_stat_t       stat_w [WINDOW_SLOTS];
    logic [SEQ_W-1:0] head;
    cell_stat_t       hst;
    logic             cfg_write;
    logic             done_now;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_SLOTS; gi++)
        begin : g_cell
            if (gi == WINDOW_SLOTS - 1)
            begin : g_tail
                srsw_cell u_cell (
                    .clk  (clk),
                    .rst_n(rst_n),
                    .ctl  (cell_ctl),
                    .din  (tail),
                    .key  (seq_reg),
                    .slot (slot_w[gi]),
                    .stat (stat_w[gi])
                );
            end
            else
            begin : g_body
                srsw_cell u_cell (
                    .clk  (clk),
                    .rst_n(rst_n),
                    .ctl  (cell_ctl),
                    .din  (slot_w[gi+1]),
                    .key  (seq_reg),
                    .slot (slot_w[gi]),
                    .stat (stat_w[gi])
                );
            end
        end
    endgenerate

    assign head     = slot_w[0];
    assign hst      = stat_w[0];
    assign done_now = (acked_count_reg > final_seq_reg);

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_RETRY_LIMIT) ? {24'd0, retry_limit_reg} : 32'd0;

    always_comb
    begin
        retry_limit_next = retry_limit_reg;
        if (cfg_write && (paddr[2] == REG_RETRY_LIMIT))
        begin
            retry_limit_next = pwdata[7:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        seq_next         = seq_reg;
        fin_next         = fin_reg;
        cnt_next         = cnt_reg;
        placed_next      = placed_reg;
        giveup_next      = giveup_reg;
        hold_valid_next  = hold_valid_reg;
        hold_seq_next    = hold_seq_reg;
        retry_next       = retry_reg;
        acked_count_next = acked_count_reg;
        final_seq_next   = final_seq_reg;
        res_valid_next   = 1'b0;
        res_next         = res_reg;
        cell_ctl.shift   = 1'b0;
        tail             = head;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next         = cmd.action;
                    seq_next        = cmd.seq;
                    fin_next        = cmd.final_req;
                    cnt_next        = '0;
                    placed_next     = 1'b0;
                    giveup_next     = 1'b0;
                    hold_valid_next = 1'b0;
                    unique case (cmd.action)
                        ACT_SEND:
                        begin
                            state_next = ST_ROT;
                        end
                        ACT_ACK:
                        begin
                            retry_next = 8'd0;
                            state_next = ST_ROT;
                        end
                        ACT_TIMEOUT:
                        begin
                            if (retry_reg >= retry_limit_reg)
                            begin
                                giveup_next = 1'b1;
                                state_next  = ST_FIN;
                            end
                            else
                            begin
                                retry_next = retry_reg + 8'd1;
                                state_next = ST_ROT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROT:
            begin
                cell_ctl.shift = 1'b1;
                unique case (op_reg)
                    ACT_SEND:
                    begin
                        if (hst.open && !placed_reg && (seq_reg < MARK_ACKED))
                        begin
                            tail        = seq_reg;
                            placed_next = 1'b1;
                            if (fin_reg)
                            begin
                                final_seq_next = seq_reg;
                            end
                        end
                    end
                    ACT_ACK:
                    begin
                        if (hst.hit && (seq_reg < MARK_ACKED))
                        begin
                            tail = MARK_ACKED;
                            if (acked_count_reg != MARK_OPEN)
                            begin
                                acked_count_next = acked_count_reg + 16'd1;
                            end
                        end
                    end
                    ACT_TIMEOUT:
                    begin
                        if (!hst.open && !hst.acked)
                        begin
                            if (hold_valid_reg)
                            begin
                                res_valid_next   = 1'b1;
                                res_next.kind    = KIND_RESEND;
                                res_next.seq_res = hold_seq_reg;
                                res_next.last    = 1'b0;
                                res_next.done_res = done_now;
                            end
                            hold_seq_next   = head;
                            hold_valid_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        tail = head;
                    end
                endcase
                if (cnt_reg == CNT_W'(WINDOW_SLOTS - 1))
                begin
                    state_next = (op_reg == ACT_ACK) ? ST_SLIDE : ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SLIDE:
            begin
                if (hst.acked)
                begin
                    cell_ctl.shift = 1'b1;
                    tail           = MARK_OPEN;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                state_next        = ST_IDLE;
                res_valid_next    = 1'b1;
                res_next.seq_res  = seq_reg;
                res_next.last     = 1'b1;
                res_next.done_res = done_now;
                unique case (op_reg)
                    ACT_SEND:
                    begin
                        res_next.kind = placed_reg ? KIND_TAKEN : KIND_FULL;
                    end
                    ACT_ACK:
                    begin
                        res_next.kind = KIND_ACKED;
                    end
                    ACT_TIMEOUT:
                    begin
                        if (giveup_reg)
                        begin
                            res_next.kind = KIND_GIVE_UP;
                        end
                        else if (hold_valid_reg)
                        begin
                            res_next.kind    = KIND_RESEND;
                            res_next.seq_res = hold_seq_reg;
                        end
                        else
                        begin
                            res_next.kind = KIND_NONE;
                        end
                    end
                    default:
                    begin
                        res_valid_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            placed_reg      <= 1'b0;
            giveup_reg      <= 1'b0;
            hold_valid_reg  <= 1'b0;
            cnt_reg         <= '0;
            op_reg          <= ACT_SEND;
            retry_reg       <= 8'd0;
            acked_count_reg <= 16'd0;
            final_seq_reg   <= FINAL_RESET;
            retry_limit_reg <= RESEND_RESET;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            placed_reg      <= placed_next;
            giveup_reg      <= giveup_next;
            hold_valid_reg  <= hold_valid_next;
            cnt_reg         <= cnt_next;
            op_reg          <= op_next;
            retry_reg       <= retry_next;
            acked_count_reg <= acked_count_next;
            final_seq_reg   <= final_seq_next;
            retry_limit_reg <= retry_limit_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg      <= seq_next;
        fin_reg      <= fin_next;
        hold_seq_reg <= hold_seq_next;
        res_reg      <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("final word shown while a command is still in progress");

    a_early_resend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (busy && (result.kind == KIND_RESEND)))
        else $error("non-final word is not a resend inside a timeout");

    a_undef_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.action == ACT_UNUSED)) |=> (!busy && !result_valid))
        else $error("undefined action started work or produced a word");

    a_retry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd.action == ACT_TIMEOUT) && (retry_reg >= retry_limit_reg))
        |=> ##1 (result_valid && (result.kind == KIND_GIVE_UP)))
        else $error("timeout at the retry limit did not give up");
`endif

endmodule

@@ design/srsw_cell.sv @@
// ----------------------------------------------------------------------------
// srsw_cell: one slot of the send window
// Holds a sequence number or a mark, takes its neighbor's word on a shift,
// and reports whether it is open, acknowledged, or matches the key.
// ----------------------------------------------------------------------------
module srsw_cell
    import srsw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [SEQ_W-1:0] din,
    input  logic [SEQ_W-1:0] key,
    output logic [SEQ_W-1:0] slot,
    output cell_stat_t       stat
);

    logic [SEQ_W-1:0] slot_reg;
    logic [SEQ_W-1:0] slot_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctl.shift)
        begin
            slot_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= MARK_OPEN;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign slot       = slot_reg;
    assign stat.open  = (slot_reg == MARK_OPEN);
    assign stat.acked = (slot_reg == MARK_ACKED);
    assign stat.hit   = (slot_reg == key);

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the selective-repeat send window
// Commands go in over the start/busy handshake, and the retry limit is set
// over the APB port while the window is idle. A tracker class mirrors the
// slots, the retry and ack counters and the final sequence, and builds the
// expected result words for each accepted command. Every result word is
// compared with the oldest expected word. The run covers a directed set of
// corner cases, random phases under several retry limits, and a closing
// pass that acks every pending slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
    import srsw_pkg::*;
();

    localparam int WINDOW_SLOTS = 5;
    localparam int LATENCY = 2 * WINDOW_SLOTS + 4;
    localparam int STALL_LIMIT = 500;
    localparam int PHASE_WORDS = 25;
    localparam logic [2:0] ADDR_RETRY_LIMIT = {REG_RETRY_LIMIT, 2'b00};

    class window_tracker;
        logic [SEQ_W-1:0] slots [WINDOW_SLOTS];
        logic [7:0]       retry_count;
        logic [15:0]      acked_count;
        logic [SEQ_W-1:0] final_seq;
        logic [7:0]       retry_limit;
        out_t             expected_words [$];
        int               errors;

        function new();
            for (int i = 0; i < WINDOW_SLOTS; i++)
            begin
                slots[i] = MARK_OPEN;
            end
            retry_count = '0;
            acked_count = '0;
            final_seq = FINAL_RESET;
            retry_limit = RESEND_RESET;
            errors = 0;
        endfunction

        function void set_retry_limit(logic [7:0] value);
            retry_limit = value;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void queue_word(logic [2:0] kind, logic [SEQ_W-1:0] s, logic last);
            out_t w;
            w.kind = kind;
            w.seq_res = s;
            w.last = last;
            w.done_res = (acked_count > final_seq);
            expected_words.push_back(w);
        endfunction

        function void note_command(in_t c);
            bit taken;
            int n;
            int emitted;
            taken = 1'b0;
            n = 0;
            emitted = 0;
            case (c.action)
                ACT_SEND:
                begin
                    if (c.seq < MARK_ACKED)
                    begin
                        for (int i = 0; i < WINDOW_SLOTS; i++)
                        begin
                            if (!taken && slots[i] == MARK_OPEN)
                            begin
                                slots[i] = c.seq;
                                if (c.final_req)
                                    final_seq = c.seq;
                                taken = 1'b1;
                            end
                        end
                    end
                    queue_word(taken ? KIND_TAKEN : KIND_FULL, c.seq, 1'b1);
                end
                ACT_ACK:
                begin
                    if (c.seq < MARK_ACKED)
                    begin
                        for (int i = 0; i < WINDOW_SLOTS; i++)
                        begin
                            if (slots[i] == c.seq)
                            begin
                                slots[i] = MARK_ACKED;
                                if (acked_count != 16'hFFFF)
                                    acked_count = acked_count + 16'd1;
                            end
                        end
                    end
                    retry_count = '0;
                    for (int k = 0; k < WINDOW_SLOTS && slots[0] == MARK_ACKED; k++)
                    begin
                        for (int i = 0; i < WINDOW_SLOTS - 1; i++)
                        begin
                            slots[i] = slots[i + 1];
                        end
                        slots[WINDOW_SLOTS - 1] = MARK_OPEN;
                    end
                    queue_word(KIND_ACKED, c.seq, 1'b1);
                end
                ACT_TIMEOUT:
                begin
                    if (retry_count >= retry_limit)
                    begin
                        queue_word(KIND_GIVE_UP, c.seq, 1'b1);
                    end
                    else
                    begin
                        retry_count = retry_count + 8'd1;
                        for (int i = 0; i < WINDOW_SLOTS; i++)
                        begin
                            if (slots[i] != MARK_ACKED && slots[i] != MARK_OPEN)
                                n++;
                        end
                        for (int i = 0; i < WINDOW_SLOTS; i++)
                        begin
                            if (slots[i] != MARK_ACKED && slots[i] != MARK_OPEN)
                            begin
                                emitted++;
                                queue_word(KIND_RESEND, slots[i], emitted == n);
                            end
                        end
                        if (n == 0)
                            queue_word(KIND_NONE, c.seq, 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_word(out_t r);
            out_t e;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual kind %0d seq %0d",
                         $time, r.kind, r.seq_res);
                return;
            end
            e = expected_words.pop_front();
            compare_field("kind", 16'(e.kind), 16'(r.kind));
            compare_field("seq_res", e.seq_res, r.seq_res);
            compare_field("last", 16'(e.last), 16'(r.last));
            compare_field("done_res", 16'(e.done_res), 16'(r.done_res));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_t         cmd;
    logic        result_valid;
    out_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    window_tracker model;
    int            stall_cycles;

    selective_repeat_send_window #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            model.check_word(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic in_t word_of(logic [1:0] act, logic [SEQ_W-1:0] s, logic fin);
        in_t c;
        c.action = act;
        c.seq = s;
        c.final_req = fin;
        return c;
    endfunction

    function automatic in_t random_word();
        int   pick;
        int   idx;
        in_t  c;
        pick = $urandom_range(0, 99);
        c.final_req = ($urandom_range(0, 7) == 0);
        c.seq = 16'($urandom_range(0, 63));
        if (pick < 35)
        begin
            c.action = ACT_SEND;
            if ($urandom_range(0, 3) == 0)
                c.seq = 16'($urandom_range(0, 65533));
        end
        else if (pick < 65)
        begin
            c.action = ACT_ACK;
            idx = $urandom_range(0, WINDOW_SLOTS - 1);
            if (model.slots[idx] < MARK_ACKED)
                c.seq = model.slots[idx];
        end
        else if (pick < 85)
        begin
            c.action = ACT_TIMEOUT;
            c.seq = 16'($urandom());
        end
        else if (pick < 93)
        begin
            c.action = ACT_ACK;
            c.seq = 16'($urandom());
        end
        else if (pick < 97)
        begin
            c.action = ACT_SEND;
            c.seq = ($urandom_range(0, 1) == 0) ? MARK_ACKED : MARK_OPEN;
        end
        else
        begin
            c.action = ACT_UNUSED;
            c.seq = 16'($urandom());
        end
        return c;
    endfunction

    task automatic issue(input in_t c, input bit steady);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        model.note_command(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (model.pending() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic program_retry_limit(input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_RETRY_LIMIT;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model.set_retry_limit(value);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[7:0] !== value)
        begin
            model.errors++;
            $display("%0t: retry limit readback mismatch, expected %0d, actual %0d",
                     $time, value, prdata[7:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [7:0]       limits [4];
        int               idx;
        model = new();
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        stall_cycles <= 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(word_of(ACT_TIMEOUT, MARK_OPEN, 1'b0), 1'b0);
        issue(word_of(ACT_ACK, MARK_OPEN, 1'b0), 1'b0);
        issue(word_of(ACT_ACK, MARK_ACKED, 1'b1), 1'b0);
        issue(word_of(ACT_SEND, 16'd0, 1'b0), 1'b0);
        issue(word_of(ACT_SEND, FINAL_RESET, 1'b0), 1'b0);
        issue(word_of(ACT_SEND, MARK_ACKED, 1'b1), 1'b0);
        issue(word_of(ACT_SEND, MARK_OPEN, 1'b1), 1'b0);
        issue(word_of(ACT_SEND, 16'd1, 1'b0), 1'b1);
        issue(word_of(ACT_SEND, 16'd2, 1'b0), 1'b1);
        issue(word_of(ACT_SEND, 16'd3, 1'b0), 1'b1);
        issue(word_of(ACT_SEND, 16'd4, 1'b1), 1'b0);
        issue(word_of(ACT_TIMEOUT, 16'd0, 1'b0), 1'b0);
        issue(word_of(ACT_ACK, 16'd1, 1'b0), 1'b0);
        issue(word_of(ACT_ACK, 16'd0, 1'b0), 1'b0);
        issue(word_of(ACT_UNUSED, MARK_OPEN, 1'b1), 1'b0);
        issue(word_of(ACT_SEND, 16'd2, 1'b0), 1'b0);
        issue(word_of(ACT_ACK, 16'd2, 1'b0), 1'b0);
        issue(word_of(ACT_SEND, 16'd7, 1'b1), 1'b0);
        issue(word_of(ACT_ACK, FINAL_RESET, 1'b0), 1'b0);
        issue(word_of(ACT_ACK, 16'd3, 1'b0), 1'b0);
        issue(word_of(ACT_SEND, 16'd8, 1'b0), 1'b0);
        issue(word_of(ACT_ACK, 16'd7, 1'b0), 1'b0);
        issue(word_of(ACT_ACK, 16'd8, 1'b0), 1'b0);
        issue(word_of(ACT_TIMEOUT, 16'd0, 1'b0), 1'b0);
        issue(word_of(ACT_UNUSED, 16'd0, 1'b0), 1'b0);
        drain();

        limits[0] = 8'd0;
        limits[1] = 8'd255;
        limits[2] = 8'd2;
        limits[3] = 8'($urandom_range(1, 8));
        for (int p = 0; p < 4; p++)
        begin
            program_retry_limit(limits[p]);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 2 && n == PHASE_WORDS / 2)
                    drain();
                issue(random_word(), p == 1);
            end
            drain();
        end

        // Ack every pending slot until the window is empty again.
        program_retry_limit(RESEND_RESET);
        idx = 0;
        while (idx < WINDOW_SLOTS)
        begin
            if (model.slots[idx] < MARK_ACKED)
            begin
                issue(word_of(ACT_ACK, model.slots[idx], 1'b0), 1'b0);
                idx = 0;
            end
            else
            begin
                idx++;
            end
        end
        issue(word_of(ACT_TIMEOUT, 16'd0, 1'b0), 1'b0);
        drain();

        if (model.pending() != 0)
        begin
            model.errors++;
            $display("%0t: %0d expected words never arrived", $time, model.pending());
        end
        if (model.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
